@@ src/ltr_pkg.sv @@
// ----------------------------------------------------------------------------
// Line-aligned trace ring: shared definitions
// Sizes, request codes and the command word passed from front end to engine.
// ----------------------------------------------------------------------------
package ltr_pkg;

  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned ADDR_W     = $clog2(RING_DEPTH);
  // Length and count fields are 13 bits wide, enough to hold RING_DEPTH itself.
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned TOTAL_W    = 64;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);
  localparam logic [7:0]       NEWLINE   = 8'h0A;

  // Encoding of func_i
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_OPEN  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_OPEN,
    OP_READ
  } ltr_op_e;

  typedef struct packed {
    ltr_op_e          op;
    logic [7:0]       data;
    logic [CNT_W-1:0] len;   // already saturated to RING_DEPTH
  } ltr_cmd_t;

endpackage

@@ src/ltr_front.sv @@
// ----------------------------------------------------------------------------
// Line-aligned trace ring: front end
// Accepts requests, drops the unused selector, saturates the open length.
// ----------------------------------------------------------------------------
module ltr_front import ltr_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [7:0]        write_byte_i,
  input  logic [CNT_W-1:0]  request_length_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output ltr_cmd_t          push_cmd_o
);

  logic is_nop;

  always_comb begin
    is_nop          = 1'b0;
    push_cmd_o.op   = OP_WRITE;
    push_cmd_o.data = write_byte_i;
    push_cmd_o.len  = (request_length_i > DEPTH_CNT) ? DEPTH_CNT : request_length_i;
    unique case (func_i)
      FUNC_WRITE: push_cmd_o.op = OP_WRITE;
      FUNC_OPEN:  push_cmd_o.op = OP_OPEN;
      FUNC_READ:  push_cmd_o.op = OP_READ;
      default:    is_nop = 1'b1;
    endcase
  end

  // Unused selector is swallowed without touching the queue.
  assign push_valid_o = in_valid_i && !is_nop;
  assign in_ready_o   = push_ready_i || is_nop;

endmodule

@@ src/ltr_queue.sv @@
// ----------------------------------------------------------------------------
// Line-aligned trace ring: command queue
// Two-entry FIFO decoupling the front end from the engine.
// ----------------------------------------------------------------------------
module ltr_queue import ltr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  ltr_cmd_t push_cmd_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output ltr_cmd_t pop_cmd_o
);

  ltr_cmd_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ src/ltr_back.sv @@
// ----------------------------------------------------------------------------
// Line-aligned trace ring: engine
// Byte store, write counter, newline scan, readout and the result register.
// ----------------------------------------------------------------------------
module ltr_back import ltr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  ltr_cmd_t          pop_cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CNT_W-1:0]  deliver_count_o,
  output logic [7:0]        read_byte_o,
  output logic              last_byte_o,
  output logic              empty_res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [ADDR_W-1:0]  rd_addr_q, rd_addr_d;    // read position modulo depth
  logic [CNT_W-1:0]   pending_q, pending_d;
  logic [ADDR_W-1:0]  scan_addr_q, scan_addr_d;
  logic [CNT_W-1:0]   scan_left_q, scan_left_d;
  logic               chk_vld_q, chk_vld_d;
  logic [CNT_W-1:0]   chk_left_q, chk_left_d;
  logic [ADDR_W-1:0]  chk_addr_q, chk_addr_d;

  logic               out_vld_q, out_vld_d;
  logic [CNT_W-1:0]   deliver_q, deliver_d;
  logic [7:0]         byte_q, byte_d;
  logic               last_q, last_d;
  logic               empty_q, empty_d;

  logic [7:0]         mem [RING_DEPTH];
  logic [7:0]         mem_q;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_raddr;

  logic               out_free, do_pop, full;
  logic [CNT_W-1:0]   avail;

  assign out_free = !out_vld_q || out_ready_i;
  assign full     = |total_q[TOTAL_W-1:ADDR_W];
  assign avail    = full ? DEPTH_CNT : total_q[CNT_W-1:0];

  assign pop_ready_o = (state_q == ST_IDLE) && (pop_cmd_i.op == OP_WRITE || out_free);
  assign do_pop      = pop_valid_i && pop_ready_o;

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    rd_addr_d   = rd_addr_q;
    pending_d   = pending_q;
    scan_addr_d = scan_addr_q;
    scan_left_d = scan_left_q;
    chk_vld_d   = 1'b0;
    chk_left_d  = chk_left_q;
    chk_addr_d  = chk_addr_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    deliver_d   = deliver_q;
    byte_d      = byte_q;
    last_d      = last_q;
    empty_d     = empty_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = rd_addr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (do_pop) begin
          unique case (pop_cmd_i.op)
            OP_WRITE: begin
              mem_we    = 1'b1;
              total_d   = total_q + TOTAL_W'(1);
              pending_d = '0;
            end
            OP_OPEN: begin
              if (avail > pop_cmd_i.len) begin
                if (pop_cmd_i.len == '0) begin
                  // Nothing to scan: empty readout.
                  pending_d = '0;
                  out_vld_d = 1'b1;
                  deliver_d = '0;
                  byte_d    = '0;
                  last_d    = 1'b0;
                  empty_d   = 1'b0;
                end else begin
                  scan_addr_d = total_q[ADDR_W-1:0] - pop_cmd_i.len[ADDR_W-1:0];
                  scan_left_d = pop_cmd_i.len;
                  state_d     = ST_SCAN;
                end
              end else begin
                // Whole history fits.
                rd_addr_d = total_q[ADDR_W-1:0] - avail[ADDR_W-1:0];
                pending_d = avail;
                out_vld_d = 1'b1;
                deliver_d = avail;
                byte_d    = '0;
                last_d    = 1'b0;
                empty_d   = 1'b0;
              end
            end
            OP_READ: begin
              if (pending_q == '0) begin
                out_vld_d = 1'b1;
                deliver_d = '0;
                byte_d    = '0;
                last_d    = 1'b0;
                empty_d   = 1'b1;
              end else begin
                mem_re  = 1'b1;
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // One read issued per cycle; its data is compared in the following cycle.
        if (chk_vld_q && mem_q == NEWLINE) begin
          rd_addr_d = chk_addr_q + ADDR_W'(1);
          pending_d = chk_left_q - CNT_W'(1);
          out_vld_d = 1'b1;
          deliver_d = chk_left_q - CNT_W'(1);
          byte_d    = '0;
          last_d    = 1'b0;
          empty_d   = 1'b0;
          state_d   = ST_IDLE;
        end else if (chk_vld_q && chk_left_q == CNT_W'(1)) begin
          // No newline in the window.
          pending_d = '0;
          out_vld_d = 1'b1;
          deliver_d = '0;
          byte_d    = '0;
          last_d    = 1'b0;
          empty_d   = 1'b0;
          state_d   = ST_IDLE;
        end else if (scan_left_q != '0) begin
          mem_re      = 1'b1;
          mem_raddr   = scan_addr_q;
          chk_vld_d   = 1'b1;
          chk_left_d  = scan_left_q;
          chk_addr_d  = scan_addr_q;
          scan_addr_d = scan_addr_q + ADDR_W'(1);
          scan_left_d = scan_left_q - CNT_W'(1);
        end
      end

      ST_READ: begin
        rd_addr_d = rd_addr_q + ADDR_W'(1);
        pending_d = pending_q - CNT_W'(1);
        out_vld_d = 1'b1;
        deliver_d = '0;
        byte_d    = mem_q;
        last_d    = (pending_q == CNT_W'(1));
        empty_d   = 1'b0;
        state_d   = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      total_q   <= '0;
      rd_addr_q <= '0;
      pending_q <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      rd_addr_q <= rd_addr_d;
      pending_q <= pending_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_addr_q <= scan_addr_d;
    scan_left_q <= scan_left_d;
    chk_left_q  <= chk_left_d;
    chk_addr_q  <= chk_addr_d;
    deliver_q   <= deliver_d;
    byte_q      <= byte_d;
    last_q      <= last_d;
    empty_q     <= empty_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[total_q[ADDR_W-1:0]] <= pop_cmd_i.data;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o     = out_vld_q;
  assign deliver_count_o = deliver_q;
  assign read_byte_o     = byte_q;
  assign last_byte_o     = last_q;
  assign empty_res_o     = empty_q;

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= DEPTH_CNT)
    else $error("pending count exceeds ring depth");

  a_busy_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_vld_q)
    else $error("result register occupied while engine busy");

  a_chk_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (state_q == ST_SCAN))
    else $error("scan compare outside scan");

  a_write_cancels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && pop_cmd_i.op == OP_WRITE) |=> (pending_q == '0))
    else $error("write did not cancel readout");

endmodule

@@ src/line_aligned_trace_ring_unit.sv @@
// ----------------------------------------------------------------------------
// Line-aligned trace ring
// Circular 4096-byte trace store with line-aligned readout.
// ----------------------------------------------------------------------------
// Usage: a write request (func 0) appends one byte, produces no result and
// cancels any open readout; writes sustain one per cycle while the engine
// is idle. An open request (func 1) saturates its length to the ring depth;
// when it asks for less than the stored history, the engine scans forward
// from the oldest wanted byte to just past the first newline, one byte per
// cycle through the store's single read port. The open's result carries the
// number of bytes the readout will deliver. A read request (func 2) goes
// through a registered store read and returns the next byte with a last-byte
// flag, or the empty flag when nothing is pending. Func 3 is accepted and
// ignored. A two-entry command queue sits between the front end and the
// engine, and the result sits in its own register, so new requests queue
// while a result waits.
// The store needs no clearing pass: only written bytes are ever read.
// ----------------------------------------------------------------------------
module line_aligned_trace_ring_unit import ltr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [7:0]        write_byte_i,
  input  logic [CNT_W-1:0]  request_length_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CNT_W-1:0]  deliver_count_o,
  output logic [7:0]        read_byte_o,
  output logic              last_byte_o,
  output logic              empty_res_o
);

  // front end -> queue
  logic     push_valid, push_ready;
  ltr_cmd_t push_cmd;
  // queue -> engine
  logic     pop_valid, pop_ready;
  ltr_cmd_t pop_cmd;

  ltr_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .write_byte_i     (write_byte_i),
    .request_length_i (request_length_i),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_cmd_o       (push_cmd)
  );

  ltr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  ltr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_cmd_i       (pop_cmd),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .deliver_count_o (deliver_count_o),
    .read_byte_o     (read_byte_o),
    .last_byte_o     (last_byte_o),
    .empty_res_o     (empty_res_o)
  );

endmodule
